### hdl/pcr_pkg.sv
package pcr_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SPACING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_MASK = 3'd4;

    // register widths and reset values
    localparam int unsigned CENTRE_W  = 10;
    localparam int unsigned RADIUS_W  = 9;
    localparam int unsigned SPACING_W = 8;
    localparam int unsigned MASK_W    = 9;
    localparam logic [SPACING_W-1:0] SPACING_RESET = 8'd50;
    localparam logic [MASK_W-1:0]    MASK_RESET    = 9'd202;

    // arc state widths
    localparam int unsigned ARC_W  = 10;
    localparam int unsigned DEC_W  = 14;
    localparam int unsigned OFFS_W = ARC_W + 1;

    // grid position fields cover up to four copies per side
    localparam int unsigned SIDE_W = 2;

    localparam int unsigned COLOUR_W = 4;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    // one pixel command: octant offset, grid position, colour, end flag
    typedef struct packed {
        logic signed [OFFS_W-1:0] dx;
        logic signed [OFFS_W-1:0] dy;
        logic [SIDE_W-1:0]        col;
        logic [SIDE_W-1:0]        row;
        logic [COLOUR_W-1:0]      colour;
        logic                     last;
    } t_pix_cmd;

endpackage

### hdl/pcr_front.sv
module pcr_front
    import pcr_pkg::*;
#(
    parameter int COPIES_PER_SIDE = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_start_req,
    input  logic                i_full,
    input  logic [RADIUS_W-1:0] i_radius,
    input  logic [MASK_W-1:0]   i_reverse_mask,
    output logic                o_stall,
    output logic                o_push,
    output t_pix_cmd            o_cmd
);

    localparam int NUM_COPIES = COPIES_PER_SIDE * COPIES_PER_SIDE;
    localparam int COPY_W = (NUM_COPIES > 1) ? $clog2(NUM_COPIES) : 1;

    typedef enum logic [2:0] {
        OCT_XY, OCT_YX, OCT_YNX, OCT_XNY, OCT_NXNY, OCT_NYNX, OCT_NYX, OCT_NXY
    } t_octant;

    logic                     r_active;
    logic [ARC_W-1:0]         r_x;
    logic [ARC_W-1:0]         r_y;
    logic signed [DEC_W-1:0]  r_dec;
    logic [COPY_W-1:0]        r_copy;
    logic [SIDE_W-1:0]        r_col;
    logic [SIDE_W-1:0]        r_row;
    t_octant                  r_oct;

    logic                     accept;
    logic                     step;
    logic signed [OFFS_W-1:0] xs;
    logic signed [OFFS_W-1:0] ys;
    logic signed [OFFS_W-1:0] dx;
    logic signed [OFFS_W-1:0] dy;
    logic signed [OFFS_W-1:0] diff;
    logic signed [OFFS_W-1:0] nx;
    logic signed [OFFS_W-1:0] ny;
    logic [DEC_W-1:0]         n_dec;
    logic [MASK_W-1:0]        mask_sh;
    logic                     oct_last;
    logic                     copy_last;
    logic                     col_last;
    logic                     arc_done;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign step    = accept && !i_start_req && r_active;
    assign o_push  = step;

    assign xs = $signed({1'b0, r_x});
    assign ys = $signed({1'b0, r_y});

    // octant reflection of the current arc point
    always_comb begin
        case (r_oct)
            OCT_XY:   begin dx = xs;  dy = ys;  end
            OCT_YX:   begin dx = ys;  dy = xs;  end
            OCT_YNX:  begin dx = ys;  dy = -xs; end
            OCT_XNY:  begin dx = xs;  dy = -ys; end
            OCT_NXNY: begin dx = -xs; dy = -ys; end
            OCT_NYNX: begin dx = -ys; dy = -xs; end
            OCT_NYX:  begin dx = -ys; dy = xs;  end
            default:  begin dx = -xs; dy = ys;  end
        endcase
    end

    // Bresenham circle decision step, used after the last pixel of a point
    assign diff = xs - ys;
    always_comb begin
        if (r_dec[DEC_W-1]) begin
            n_dec = r_dec + DEC_W'({r_x, 2'b00}) + DEC_W'(6);
            ny    = ys;
        end else begin
            n_dec = r_dec + {diff[OFFS_W-1], diff, 2'b00} + DEC_W'(10);
            ny    = ys - OFFS_W'(1);
        end
    end
    assign nx       = xs + OFFS_W'(1);
    assign arc_done = nx > ny;

    assign oct_last  = (r_oct == OCT_NXY);
    assign copy_last = (r_copy == COPY_W'(NUM_COPIES - 1));
    assign col_last  = (r_col == SIDE_W'(COPIES_PER_SIDE - 1));

    // copies past the mask width shift in zeros and keep forward colours
    assign mask_sh = i_reverse_mask >> r_copy;

    // pixel command for the queue
    always_comb begin
        o_cmd.dx  = dx;
        o_cmd.dy  = dy;
        o_cmd.col = r_col;
        o_cmd.row = r_row;
        if (mask_sh[0]) begin
            o_cmd.colour = COLOUR_W'(8) - COLOUR_W'(r_oct);
        end else begin
            o_cmd.colour = COLOUR_W'(r_oct) + COLOUR_W'(1);
        end
        o_cmd.last = oct_last && copy_last && arc_done;
    end

    // arc sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_dec    <= '0;
            r_copy   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_oct    <= OCT_XY;
        end else if (accept && i_start_req) begin
            r_active <= 1'b1;
            r_x      <= '0;
            r_y      <= ARC_W'(i_radius);
            r_dec    <= DEC_W'(3) - DEC_W'({i_radius, 1'b0});
            r_copy   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_oct    <= OCT_XY;
        end else if (step) begin
            r_oct <= t_octant'(r_oct + 3'd1);
            if (oct_last) begin
                if (!copy_last) begin
                    r_copy <= r_copy + COPY_W'(1);
                    if (col_last) begin
                        r_col <= '0;
                        r_row <= r_row + SIDE_W'(1);
                    end else begin
                        r_col <= r_col + SIDE_W'(1);
                    end
                end else begin
                    r_copy <= '0;
                    r_col  <= '0;
                    r_row  <= '0;
                    r_dec  <= n_dec;
                    r_x    <= nx[ARC_W-1:0];
                    r_y    <= ny[ARC_W-1:0];
                    if (arc_done) begin
                        r_active <= 1'b0;
                    end
                end
            end
        end
    end

endmodule

### hdl/pcr_queue.sv
module pcr_queue
    import pcr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_pix_cmd i_cmd,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_valid,
    output t_pix_cmd o_cmd
);

    t_pix_cmd           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

### hdl/pcr_back.sv
module pcr_back
    import pcr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  t_pix_cmd                     i_cmd,
    input  logic [CENTRE_W-1:0]          i_centre_x,
    input  logic [CENTRE_W-1:0]          i_centre_y,
    input  logic [SPACING_W-1:0]         i_grid_spacing,
    input  logic                         i_stall,
    output logic                         o_pop,
    output logic                         o_valid,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic [COLOUR_W-1:0]          o_colour,
    output logic                         o_last_pixel
);

    localparam int SUM_W = (COORD_BITS > 12) ? COORD_BITS : 12;
    localparam int OFF_W = SIDE_W + SPACING_W;

    logic                         r_valid;
    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;
    logic [COLOUR_W-1:0]          r_colour;
    logic                         r_last;

    logic                         load;
    logic [OFF_W-1:0]             off_x;
    logic [OFF_W-1:0]             off_y;
    logic [SUM_W-1:0]             sum_x;
    logic [SUM_W-1:0]             sum_y;

    assign load  = i_valid && (!r_valid || !i_stall);
    assign o_pop = load;

    // copy centre plus octant offset, wrapped to the coordinate width
    assign off_x = OFF_W'(i_cmd.col) * OFF_W'(i_grid_spacing);
    assign off_y = OFF_W'(i_cmd.row) * OFF_W'(i_grid_spacing);
    assign sum_x = SUM_W'(i_centre_x) + SUM_W'(off_x) + SUM_W'(i_cmd.dx);
    assign sum_y = SUM_W'(i_centre_y) + SUM_W'(off_y) + SUM_W'(i_cmd.dy);

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px     <= sum_x[COORD_BITS-1:0];
            r_py     <= sum_y[COORD_BITS-1:0];
            r_colour <= i_cmd.colour;
            r_last   <= i_cmd.last;
        end
    end

    assign o_valid      = r_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_colour     = r_colour;
    assign o_last_pixel = r_last;

endmodule

### hdl/patterned_circle_rasterizer_unit.sv
// channel  | handshake                 | payload
// ---------+---------------------------+---------------------------------------------
// in       | i_in_valid / o_in_stall   | i_start_req
// out      | o_out_valid / i_out_stall | o_pixel_x, o_pixel_y, o_colour, o_last_pixel
// cfg      | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// one pixel per clock sustained unless i_out_stall or a full queue holds the flow; a request
// enters the queue at its input transfer edge and later reaches the output register from its head
// a four-entry queue sits between the arc sequencer and the coordinate stage
// o_in_stall is high while that queue is full; a valid output pixel holds under i_out_stall
// reset is synchronous and active low; it clears the arc state, the queue and the output
// valid flag and loads the configuration reset values
module patterned_circle_rasterizer_unit
    import pcr_pkg::*;
#(
    parameter int COPIES_PER_SIDE = 3,
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_start_req,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic [COLOUR_W-1:0]          o_colour,
    output logic                         o_last_pixel,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    logic [CENTRE_W-1:0]  r_centre_x;
    logic [CENTRE_W-1:0]  r_centre_y;
    logic [RADIUS_W-1:0]  r_radius;
    logic [SPACING_W-1:0] r_grid_spacing;
    logic [MASK_W-1:0]    r_reverse_mask;

    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_valid;
    t_pix_cmd             push_cmd;
    t_pix_cmd             head_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x     <= '0;
            r_centre_y     <= '0;
            r_radius       <= '0;
            r_grid_spacing <= SPACING_RESET;
            r_reverse_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTRE_X:     r_centre_x     <= i_cfg_data[CENTRE_W-1:0];
                CFG_CENTRE_Y:     r_centre_y     <= i_cfg_data[CENTRE_W-1:0];
                CFG_RADIUS:       r_radius       <= i_cfg_data[RADIUS_W-1:0];
                CFG_GRID_SPACING: r_grid_spacing <= i_cfg_data[SPACING_W-1:0];
                CFG_REVERSE_MASK: r_reverse_mask <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // arc sequencer
    pcr_front #(
        .COPIES_PER_SIDE(COPIES_PER_SIDE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_start_req   (i_start_req),
        .i_full        (q_full),
        .i_radius      (r_radius),
        .i_reverse_mask(r_reverse_mask),
        .o_stall       (o_in_stall),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    // pixel command queue
    pcr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (push_cmd),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_cmd  (head_cmd)
    );

    // coordinate stage and output register
    pcr_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_cmd         (head_cmd),
        .i_centre_x    (r_centre_x),
        .i_centre_y    (r_centre_y),
        .i_grid_spacing(r_grid_spacing),
        .i_stall       (i_out_stall),
        .o_pop         (q_pop),
        .o_valid       (o_out_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_colour      (o_colour),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

### hdl/pcr_checker.sv
module pcr_checker
    import pcr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic signed [COORD_BITS-1:0] o_pixel_x,
    input logic signed [COORD_BITS-1:0] o_pixel_y,
    input logic [COLOUR_W-1:0]          o_colour,
    input logic                         o_last_pixel
);

    // a stalled pixel stays put until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_x)
            && $stable(o_pixel_y) && $stable(o_colour) && $stable(o_last_pixel))
        else $error("stalled output changed");

    // palette index always one through eight
    a_colour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_colour != '0 && o_colour <= COLOUR_W'(8))
        else $error("colour out of range");

    // nothing pending and not stalled right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("state not cleared by reset");

    // the input stall only rises after an input request was offered
    a_stall_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("input stall without a preceding transfer");

endmodule

bind patterned_circle_rasterizer_unit pcr_checker #(
    .COORD_BITS(COORD_BITS)
) u_pcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pixel_x   (o_pixel_x),
    .o_pixel_y   (o_pixel_y),
    .o_colour    (o_colour),
    .o_last_pixel(o_last_pixel)
);

### tb/tb_patterned_circle_rasterizer_unit.sv
`timescale 1ns / 1ps

module tb_patterned_circle_rasterizer_unit;
    import pcr_pkg::*;

    localparam int COPIES_PER_SIDE = 3;
    localparam int COORD_BITS = 12;
    localparam int NUM_COPIES = COPIES_PER_SIDE * COPIES_PER_SIDE;
    localparam int NUM_REFL = 8;
    // pipeline depth plus queue depth, with margin
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_CYCLES = 600_000;
    localparam int MAX_REPORTS = 100;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    // octant reflections in emission order
    typedef enum logic [2:0] {
        REFL_XY, REFL_YX, REFL_YNX, REFL_XNY, REFL_NXNY, REFL_NYNX, REFL_NYX, REFL_NXY
    } t_refl;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COLOUR_W-1:0]   colour;
        logic                  last;
    } t_pixel;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic                         i_start_req;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic signed [COORD_BITS-1:0] o_pixel_x;
    logic signed [COORD_BITS-1:0] o_pixel_y;
    logic [COLOUR_W-1:0]          o_colour;
    logic                         o_last_pixel;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_DATA_W-1:0]        i_cfg_data;

    // register copies
    logic [CENTRE_W-1:0]  cfg_centre_x;
    logic [CENTRE_W-1:0]  cfg_centre_y;
    logic [RADIUS_W-1:0]  cfg_radius;
    logic [SPACING_W-1:0] cfg_spacing;
    logic [MASK_W-1:0]    cfg_rev_mask;

    // arc walk state
    logic [ARC_W-1:0]        walk_x;
    logic [ARC_W-1:0]        walk_y;
    logic signed [DEC_W-1:0] walk_err;
    int                      grid_pos;
    t_refl                   refl;
    logic                    drawing;

    t_pixel pending_pixels[$];
    int     failures;
    int     requests_sent;
    int     cycles;
    int     in_gap_pct;
    int     out_stall_pct;

    patterned_circle_rasterizer_unit #(
        .COPIES_PER_SIDE(COPIES_PER_SIDE),
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_start_req(i_start_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_pixel_x(o_pixel_x),
        .o_pixel_y(o_pixel_y),
        .o_colour(o_colour),
        .o_last_pixel(o_last_pixel),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // work out the pixel a request produces, if any
    function automatic void trace_arc(input logic start);
        int x, y, dx, dy, nx, ny, col, row;
        logic rev;
        t_pixel p;
        if (start) begin
            walk_x = '0;
            walk_y = ARC_W'(cfg_radius);
            walk_err = DEC_W'(3 - 2 * int'(cfg_radius));
            grid_pos = 0;
            refl = REFL_XY;
            drawing = 1'b1;
            return;
        end
        if (!drawing) return;

        x = int'(walk_x);
        y = int'(walk_y);
        case (refl)
            REFL_XY: begin dx = x; dy = y; end
            REFL_YX: begin dx = y; dy = x; end
            REFL_YNX: begin dx = y; dy = -x; end
            REFL_XNY: begin dx = x; dy = -y; end
            REFL_NXNY: begin dx = -x; dy = -y; end
            REFL_NYNX: begin dx = -y; dy = -x; end
            REFL_NYX: begin dx = -y; dy = x; end
            default: begin dx = -x; dy = y; end
        endcase

        col = grid_pos % COPIES_PER_SIDE;
        row = grid_pos / COPIES_PER_SIDE;
        p.x = COORD_BITS'(int'(cfg_centre_x) + col * int'(cfg_spacing) + dx);
        p.y = COORD_BITS'(int'(cfg_centre_y) + row * int'(cfg_spacing) + dy);
        rev = (grid_pos < MASK_W) && cfg_rev_mask[grid_pos];
        p.colour = rev ? COLOUR_W'(NUM_REFL - int'(refl)) : COLOUR_W'(int'(refl) + 1);
        p.last = 1'b0;

        // step reflection, then copy, then the arc itself
        if (refl != REFL_NXY) begin
            refl = t_refl'(refl + 1);
        end else begin
            refl = REFL_XY;
            if (grid_pos + 1 < NUM_COPIES) begin
                grid_pos++;
            end else begin
                grid_pos = 0;
                if (walk_err < 0) begin
                    walk_err = DEC_W'(walk_err + 4 * x + 6);
                    nx = x + 1;
                    ny = y;
                end else begin
                    walk_err = DEC_W'(walk_err + 4 * (x - y) + 10);
                    nx = x + 1;
                    ny = y - 1;
                end
                if (nx > ny) begin
                    drawing = 1'b0;
                    p.last = 1'b1;
                end
                walk_x = ARC_W'(nx);
                walk_y = ARC_W'(ny);
            end
        end
        pending_pixels.push_back(p);
    endfunction

    function automatic void check_field(input string what, input logic [COORD_BITS-1:0] want,
                                        input logic [COORD_BITS-1:0] got);
        if (want !== got) begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t: %s expected %h actual %h", $time, what, want, got);
        end
    endfunction

    // compare each output transfer with the oldest expected pixel
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected pixel expected none actual x=%h y=%h c=%0d l=%b",
                             $time, o_pixel_x, o_pixel_y, o_colour, o_last_pixel);
            end else begin
                want = pending_pixels.pop_front();
                check_field("pixel_x", want.x, o_pixel_x);
                check_field("pixel_y", want.y, o_pixel_y);
                check_field("colour", COORD_BITS'(want.colour), COORD_BITS'(o_colour));
                check_field("last_pixel", COORD_BITS'(want.last), COORD_BITS'(o_last_pixel));
            end
        end
    end

    // one input transfer, with a random gap ahead of it
    task automatic send_request(input logic start);
        while ($urandom_range(99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_req <= start;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (start || drawing) requests_sent++;
        trace_arc(start);
    endtask

    // stop sending and let every expected pixel come out
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic finish_circle();
        while (drawing) send_request(1'b0);
    endtask

    // write all registers once the block is quiet, plus one unmapped index
    task automatic apply_setup(input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
                               input logic [CFG_DATA_W-1:0] rad,
                               input logic [CFG_DATA_W-1:0] spacing,
                               input logic [CFG_DATA_W-1:0] mask);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        idx = '{CFG_CENTRE_X, CFG_CENTRE_Y, CFG_RADIUS, CFG_GRID_SPACING, CFG_REVERSE_MASK,
                CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST))};
        val = '{cx, cy, rad, spacing, mask, CFG_DATA_W'($urandom)};
        drain_pipeline();
        for (int i = 0; i < 6; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= val[i];
            @(posedge i_clk);
            case (idx[i])
                CFG_CENTRE_X: cfg_centre_x = val[i][CENTRE_W-1:0];
                CFG_CENTRE_Y: cfg_centre_y = val[i][CENTRE_W-1:0];
                CFG_RADIUS: cfg_radius = val[i][RADIUS_W-1:0];
                CFG_GRID_SPACING: cfg_spacing = val[i][SPACING_W-1:0];
                CFG_REVERSE_MASK: cfg_rev_mask = val[i][MASK_W-1:0];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    // reset register values, with a request while idle
    task automatic test_reset_values();
        send_request(1'b0);
        send_request(1'b1);
        finish_circle();
        send_request(1'b0);
    endtask

    // register extremes: zero radius at the far corner, then a tiny circle near the origin
    task automatic test_register_extremes();
        apply_setup(10'h3FF, 10'h3FF, 10'h200, 10'h3FF, 10'h3FF);
        send_request(1'b1);
        finish_circle();
        apply_setup(10'h000, 10'h000, 10'h001, 10'h300, 10'h000);
        send_request(1'b1);
        repeat (100) send_request(1'b0);
        // let the pattern run dry before continuing
        drain_pipeline();
        finish_circle();
        send_request(1'b0);
    endtask

    // a start abandons the circle in progress; back-to-back starts emit nothing
    task automatic test_restart();
        apply_setup(10'd300, 10'd200, 10'd3, 10'd20, 10'h0AA);
        send_request(1'b1);
        repeat (20) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b1);
        finish_circle();
    endtask

    // random register settings, mostly small circles run to the end
    task automatic test_random_circles(input int n_requests);
        int stop_at, cut, done;
        logic [CFG_DATA_W-1:0] rad;
        stop_at = requests_sent + n_requests;
        while (requests_sent < stop_at) begin
            rad = {1'($urandom),
                   9'(($urandom_range(7) == 0) ? $urandom_range(16) : $urandom_range(3))};
            apply_setup(10'($urandom), 10'($urandom), rad, 10'($urandom), 10'($urandom));
            if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) send_request(1'b0);
            send_request(1'b1);
            cut = ($urandom_range(4) == 0) ? $urandom_range(100) : -1;
            done = 0;
            while (drawing && requests_sent < stop_at) begin
                send_request(done == cut);
                done++;
            end
        end
    endtask

    // opening points of the largest circle, decision at its most negative
    task automatic test_largest_circle();
        apply_setup(10'h3FF, 10'h000, 10'h3FF, 10'h0FF, 10'($urandom));
        send_request(1'b1);
        repeat (2 * NUM_COPIES * NUM_REFL) send_request(1'b0);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_start_req <= 1'b0;
        i_out_stall <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_CENTRE_X;
        i_cfg_data <= '0;
        cfg_centre_x = '0;
        cfg_centre_y = '0;
        cfg_radius = '0;
        cfg_spacing = SPACING_RESET;
        cfg_rev_mask = MASK_RESET;
        walk_x = '0;
        walk_y = '0;
        walk_err = '0;
        grid_pos = 0;
        refl = REFL_XY;
        drawing = 1'b0;
        failures = 0;
        requests_sent = 0;
        cycles = 0;
        in_gap_pct = 8;
        out_stall_pct = 84;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_register_extremes();
        test_restart();
        test_random_circles(430);

        in_gap_pct = 84;
        out_stall_pct = 8;
        test_random_circles(430);

        in_gap_pct = 0;
        out_stall_pct = 0;
        test_largest_circle();
        test_random_circles(430);

        drain_pipeline();
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
